// ===== design/bae_pkg.sv =====
// Package for the block-averaging statistics estimator.
// Holds the channel word types, accumulator widths and the sequencer states.
// No dependencies.
package bae_pkg;

    // Fixed field and accumulator widths
    localparam int SAMPLE_W   = 24;
    localparam int LEN_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 40;
    localparam int MEAN_TOT_W = 40;
    localparam int SQ_TOT_W   = 64;
    localparam int DIV_W      = 64;   // dividend / quotient shift register
    localparam int ROOT_W     = 32;   // floor sqrt of a 64-bit value
    localparam int REM_W      = 34;   // sqrt remainder, at most 2*root
    localparam int UNIT_W     = 36;   // shared trial-subtract width
    localparam int ITER_W     = 6;    // up to 64 iterations

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd1000;

    // Input word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [COUNT_W-1:0]  block_index;
        logic [SAMPLE_W-1:0] running_mean;
        logic [SAMPLE_W-1:0] std_error;
        logic                saturated;
    } out_word_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_SQR_MEAN,
        ST_ACC_SQR,
        ST_DIV_AVG,
        ST_SQR_AVG,
        ST_DIV_MSQ,
        ST_SUB_VAR,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

// ===== design/block_average_error.sv =====
// Block-averaging statistics estimator, top level.
// Depends on bae_pkg (word types, widths, sequencer states).
//
// Samples that do not close a block are taken one per cycle. The sample that
// closes a block starts a sequence on one shared trial-subtract unit, used as
// a radix-2 divider and as a bit-pair square root: block mean, running mean,
// mean of squares, variance divide and root, plus four multiply, accumulate
// and subtract steps. The input stays not ready until the sequence ends (it is
// shorter for the first block after reset or restart, which skips the variance
// and root, and once the block counter has saturated, which skips the block
// mean), and longer only if the previous result word has not been taken.
// A finished word sits in an output register, so the next samples are taken
// while it waits. The user must write the block length through cfg_we/cfg_wdata
// only while the block is idle; the block itself does not enforce it. 0 acts as 1.
module block_average_error #(
    parameter int MAX_BLOCKS  = 65535,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         cfg_we,
    input  logic [bae_pkg::LEN_W-1:0]    cfg_wdata,
    // input words
    input  logic                         s_valid,
    output logic                         s_ready,
    input  bae_pkg::in_word_t            s_data,
    // result words
    output logic                         m_valid,
    input  logic                         m_ready,
    output bae_pkg::out_word_t           m_data
);

    localparam logic [63:0] SAMPLE_MAX = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam logic [bae_pkg::COUNT_W-1:0] MAX_CNT = bae_pkg::COUNT_W'(MAX_BLOCKS);

    // Control and state registers
    bae_pkg::state_t                   state_reg, state_next;
    logic [bae_pkg::LEN_W-1:0]         block_len_reg, block_len_next;
    logic [bae_pkg::SUM_W-1:0]         sample_sum_reg, sample_sum_next;
    logic [bae_pkg::COUNT_W-1:0]       sample_count_reg, sample_count_next;
    logic [bae_pkg::COUNT_W-1:0]       block_count_reg, block_count_next;
    logic [bae_pkg::MEAN_TOT_W-1:0]    mean_total_reg, mean_total_next;
    logic [bae_pkg::SQ_TOT_W-1:0]      square_total_reg, square_total_next;
    logic                              m_valid_reg, m_valid_next;

    // Datapath registers
    logic [bae_pkg::DIV_W-1:0]         quo_reg, quo_next;
    logic [bae_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [bae_pkg::LEN_W-1:0]         den_reg, den_next;
    logic [bae_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [bae_pkg::ITER_W-1:0]        iter_reg, iter_next;
    logic [63:0]                       prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]            avg_reg, avg_next;
    bae_pkg::out_word_t                out_reg, out_next;

    // Intake signals
    logic [31:0]                       sample_ext;
    logic [SAMPLE_BITS-1:0]            x_val;
    logic [bae_pkg::LEN_W-1:0]         len_eff;
    logic [bae_pkg::SUM_W-1:0]         sum_base, sum_new;
    logic [bae_pkg::COUNT_W-1:0]       count_base, count_new, bc_base;
    logic [bae_pkg::MEAN_TOT_W-1:0]    mt_base;
    logic [bae_pkg::SQ_TOT_W-1:0]      st_base;
    logic                              blk_done;

    // Shared unit and helpers
    logic                              sqrt_mode;
    logic [bae_pkg::UNIT_W-1:0]        unit_a, unit_b, unit_diff;
    logic                              unit_borrow, unit_ge;
    logic [SAMPLE_BITS-1:0]            quo_sat, root_sat;
    logic [2*SAMPLE_BITS-1:0]          sq_prod;
    logic [63:0]                       var_num;
    logic [63:0]                       root_ext;
    logic [31:0]                       avg_ext, err_ext;
    logic                              out_free;

    // Intake: sample masking, restart and block-completion test
    assign sample_ext = 32'(s_data.sample);
    assign x_val      = sample_ext[SAMPLE_BITS-1:0];
    assign len_eff    = (block_len_reg == '0) ? bae_pkg::LEN_W'(1) : block_len_reg;
    assign sum_base   = s_data.restart ? '0 : sample_sum_reg;
    assign count_base = s_data.restart ? '0 : sample_count_reg;
    assign bc_base    = s_data.restart ? '0 : block_count_reg;
    assign mt_base    = s_data.restart ? '0 : mean_total_reg;
    assign st_base    = s_data.restart ? '0 : square_total_reg;
    assign sum_new    = sum_base + bae_pkg::SUM_W'(x_val);
    assign count_new  = count_base + bae_pkg::COUNT_W'(1);
    assign blk_done   = !((count_new < len_eff) && (count_new != '0));

    // Shared trial-subtract unit: divide step or square-root step
    assign sqrt_mode = (state_reg == bae_pkg::ST_SQRT);
    always_comb begin
        if (sqrt_mode) begin
            unit_a = {rem_reg, quo_reg[bae_pkg::DIV_W-1 -: 2]};
            unit_b = {2'b00, root_reg, 2'b01};
        end else begin
            unit_a = {19'd0, rem_reg[bae_pkg::LEN_W-1:0], quo_reg[bae_pkg::DIV_W-1]};
            unit_b = {20'd0, den_reg};
        end
    end
    assign {unit_borrow, unit_diff} = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge = ~unit_borrow;

    // Saturation to the sample range, square, variance numerator
    assign quo_sat  = (quo_reg > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
                                             : quo_reg[SAMPLE_BITS-1:0];
    assign sq_prod  = quo_sat * quo_sat;
    assign var_num  = (quo_reg > prod_reg) ? (quo_reg - prod_reg) : 64'd0;
    assign root_ext = 64'(root_reg);
    assign root_sat = (root_ext > SAMPLE_MAX) ? SAMPLE_MAX[SAMPLE_BITS-1:0]
                                              : root_ext[SAMPLE_BITS-1:0];
    assign avg_ext  = 32'(avg_reg);
    assign err_ext  = 32'(root_sat);
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bae_pkg::ST_IDLE: begin
                if (s_valid && blk_done) begin
                    state_next = (bc_base < MAX_CNT) ? bae_pkg::ST_DIV_MEAN
                                                     : bae_pkg::ST_DIV_AVG;
                end
            end
            bae_pkg::ST_DIV_MEAN: begin
                if (iter_reg == '0) state_next = bae_pkg::ST_SQR_MEAN;
            end
            bae_pkg::ST_SQR_MEAN: state_next = bae_pkg::ST_ACC_SQR;
            bae_pkg::ST_ACC_SQR:  state_next = bae_pkg::ST_DIV_AVG;
            bae_pkg::ST_DIV_AVG: begin
                if (iter_reg == '0) state_next = bae_pkg::ST_SQR_AVG;
            end
            bae_pkg::ST_SQR_AVG: begin
                state_next = (block_count_reg > bae_pkg::COUNT_W'(1)) ? bae_pkg::ST_DIV_MSQ
                                                                      : bae_pkg::ST_DONE;
            end
            bae_pkg::ST_DIV_MSQ: begin
                if (iter_reg == '0) state_next = bae_pkg::ST_SUB_VAR;
            end
            bae_pkg::ST_SUB_VAR: state_next = bae_pkg::ST_DIV_VAR;
            bae_pkg::ST_DIV_VAR: begin
                if (iter_reg == '0) state_next = bae_pkg::ST_SQRT;
            end
            bae_pkg::ST_SQRT: begin
                if (iter_reg == '0) state_next = bae_pkg::ST_DONE;
            end
            bae_pkg::ST_DONE: begin
                if (out_free) state_next = bae_pkg::ST_IDLE;
            end
            default: state_next = bae_pkg::ST_IDLE;
        endcase
    end

    // Datapath and accumulator updates
    always_comb begin
        block_len_next    = cfg_we ? cfg_wdata : block_len_reg;
        sample_sum_next   = sample_sum_reg;
        sample_count_next = sample_count_reg;
        block_count_next  = block_count_reg;
        mean_total_next   = mean_total_reg;
        square_total_next = square_total_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        root_next         = root_reg;
        iter_next         = iter_reg;
        prod_next         = prod_reg;
        avg_next          = avg_reg;
        out_next          = out_reg;

        case (state_reg)
            bae_pkg::ST_IDLE: begin
                if (s_valid) begin
                    block_count_next  = bc_base;
                    mean_total_next   = mt_base;
                    square_total_next = st_base;
                    if (blk_done) begin
                        sample_sum_next   = '0;
                        sample_count_next = '0;
                        rem_next          = '0;
                        iter_next         = '1;
                        if (bc_base < MAX_CNT) begin
                            quo_next = bae_pkg::DIV_W'(sum_new);
                            den_next = len_eff;
                        end else begin
                            // counter held: statistics repeat from held totals
                            quo_next = bae_pkg::DIV_W'(mt_base);
                            den_next = bc_base;
                        end
                    end else begin
                        sample_sum_next   = sum_new;
                        sample_count_next = count_new;
                    end
                end
            end
            bae_pkg::ST_DIV_MEAN, bae_pkg::ST_DIV_AVG, bae_pkg::ST_DIV_MSQ: begin
                // one quotient bit per cycle
                rem_next  = unit_ge ? {18'd0, unit_diff[bae_pkg::LEN_W-1:0]}
                                    : {18'd0, unit_a[bae_pkg::LEN_W-1:0]};
                quo_next  = {quo_reg[bae_pkg::DIV_W-2:0], unit_ge};
                iter_next = iter_reg - 1'b1;
            end
            bae_pkg::ST_DIV_VAR: begin
                rem_next  = unit_ge ? {18'd0, unit_diff[bae_pkg::LEN_W-1:0]}
                                    : {18'd0, unit_a[bae_pkg::LEN_W-1:0]};
                quo_next  = {quo_reg[bae_pkg::DIV_W-2:0], unit_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0) begin
                    // quotient stays in place as the radicand
                    rem_next  = '0;
                    root_next = '0;
                    iter_next = bae_pkg::ITER_W'(bae_pkg::ROOT_W - 1);
                end
            end
            bae_pkg::ST_SQR_MEAN: begin
                mean_total_next  = mean_total_reg + bae_pkg::MEAN_TOT_W'(quo_sat);
                block_count_next = block_count_reg + bae_pkg::COUNT_W'(1);
                prod_next        = 64'(sq_prod);
            end
            bae_pkg::ST_ACC_SQR: begin
                square_total_next = square_total_reg + prod_reg;
                quo_next  = bae_pkg::DIV_W'(mean_total_reg);
                den_next  = block_count_reg;
                rem_next  = '0;
                iter_next = '1;
            end
            bae_pkg::ST_SQR_AVG: begin
                avg_next  = quo_sat;
                prod_next = 64'(sq_prod);
                root_next = '0;
                quo_next  = square_total_reg;
                den_next  = block_count_reg;
                rem_next  = '0;
                iter_next = '1;
            end
            bae_pkg::ST_SUB_VAR: begin
                quo_next  = var_num;
                den_next  = block_count_reg - bae_pkg::COUNT_W'(1);
                rem_next  = '0;
                iter_next = '1;
            end
            bae_pkg::ST_SQRT: begin
                // one root bit per cycle, two radicand bits consumed
                rem_next  = unit_ge ? unit_diff[bae_pkg::REM_W-1:0]
                                    : unit_a[bae_pkg::REM_W-1:0];
                root_next = {root_reg[bae_pkg::ROOT_W-2:0], unit_ge};
                quo_next  = {quo_reg[bae_pkg::DIV_W-3:0], 2'b00};
                iter_next = iter_reg - 1'b1;
            end
            bae_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    out_next.block_index  = block_count_reg;
                    out_next.running_mean = avg_ext[bae_pkg::SAMPLE_W-1:0];
                    out_next.std_error    = err_ext[bae_pkg::SAMPLE_W-1:0];
                    out_next.saturated    = (block_count_reg >= MAX_CNT);
                end
            end
            default: begin
                m_valid_next = m_valid_reg && !m_ready;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bae_pkg::ST_IDLE;
            block_len_reg    <= bae_pkg::LEN_RESET;
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            block_count_reg  <= '0;
            mean_total_reg   <= '0;
            square_total_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            block_len_reg    <= block_len_next;
            sample_sum_reg   <= sample_sum_next;
            sample_count_reg <= sample_count_next;
            block_count_reg  <= block_count_next;
            mean_total_reg   <= mean_total_next;
            square_total_reg <= square_total_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        root_reg <= root_next;
        iter_reg <= iter_next;
        prod_reg <= prod_next;
        avg_reg  <= avg_next;
        out_reg  <= out_next;
    end

    // Ports
    assign s_ready = (state_reg == bae_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    // a result word only appears out of the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bae_pkg::ST_DONE))
        else $error("result word raised outside the final state");

    // block counter never passes its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        block_count_reg <= MAX_CNT)
        else $error("block counter beyond limit");

    // block counter only steps by one or clears
    assert property (@(posedge aclk) disable iff (!aresetn)
        (block_count_reg == $past(block_count_reg)) ||
        (block_count_reg == $past(block_count_reg) + bae_pkg::COUNT_W'(1)) ||
        (block_count_reg == '0))
        else $error("block counter jumped");

    // divider partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bae_pkg::ST_DIV_MEAN || state_reg == bae_pkg::ST_DIV_AVG ||
         state_reg == bae_pkg::ST_DIV_MSQ  || state_reg == bae_pkg::ST_DIV_VAR)
        |-> (rem_reg < bae_pkg::REM_W'(den_reg)))
        else $error("divider remainder out of range");

    // square-root remainder bounded by twice the partial root
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bae_pkg::ST_SQRT) |-> (rem_reg <= {1'b0, root_reg, 1'b0}))
        else $error("square-root remainder out of range");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for block_average_error: block-averaging statistics over a sample stream.
// Predicts each result word from its own copy of the accumulators and checks it.
// Depends on bae_pkg and design/block_average_error.sv.
module tb_top;

    // Block limit at the block's default
    localparam int BLOCK_LIMIT = 65535;
    localparam logic [63:0] SAMPLE_LIMIT = (64'd1 << bae_pkg::SAMPLE_W) - 64'd1;
    localparam int BUSY_CYCLES = 300;   // longest block-closing sequence plus margin
    localparam int END_CYCLES = 400;
    localparam int HOLD_CYCLES = 1500;
    localparam int QUIET_LIMIT = 20000;

    typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGES, MIX_LOW} mix_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [bae_pkg::LEN_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    bae_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    bae_pkg::out_word_t m_data;

    // Stimulus control, written by the sequence below
    logic steady = 1'b0;
    logic pressure = 1'b0;

    bae_pkg::in_word_t sample_queue[$];
    bae_pkg::out_word_t stats_due[$];
    int n_queued = 0;
    int words_taken = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    // Predicted accumulators and block length
    logic [bae_pkg::LEN_W-1:0] block_len = bae_pkg::LEN_RESET;
    logic [bae_pkg::SUM_W-1:0] run_sum = '0;
    logic [bae_pkg::COUNT_W-1:0] run_count = '0;
    logic [bae_pkg::COUNT_W-1:0] blocks_done = '0;
    logic [bae_pkg::MEAN_TOT_W-1:0] means_total = '0;
    logic [bae_pkg::SQ_TOT_W-1:0] squares_total = '0;

    block_average_error #(
        .MAX_BLOCKS(BLOCK_LIMIT),
        .SAMPLE_BITS(bae_pkg::SAMPLE_W)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Bitwise floor square root, one result bit per step from the top
    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        int i;
        root = '0;
        for (i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Take one sample into the block sum; on block close, queue the statistics word
    task automatic update_block_stats(input bae_pkg::in_word_t w);
        logic [63:0] eff_len;
        logic [63:0] blk_mean;
        logic [63:0] k;
        logic [63:0] avg;
        logic [63:0] msq;
        logic [63:0] var_q;
        logic [63:0] err;
        bae_pkg::out_word_t r;
        eff_len = (block_len == '0) ? 64'd1 : 64'(block_len);
        if (w.restart) begin
            run_sum = '0;
            run_count = '0;
            blocks_done = '0;
            means_total = '0;
            squares_total = '0;
        end
        run_sum = run_sum + bae_pkg::SUM_W'(w.sample);
        run_count = run_count + 1'b1;
        if (64'(run_count) < eff_len && run_count != '0) begin
            return;
        end
        // once saturated, the closed block is dropped
        if (blocks_done < BLOCK_LIMIT) begin
            blk_mean = 64'(run_sum) / eff_len;
            if (blk_mean > SAMPLE_LIMIT) begin
                blk_mean = SAMPLE_LIMIT;
            end
            means_total = means_total + blk_mean[bae_pkg::MEAN_TOT_W-1:0];
            squares_total = squares_total + blk_mean * blk_mean;
            blocks_done = blocks_done + 1'b1;
        end
        run_sum = '0;
        run_count = '0;
        k = 64'(blocks_done);
        avg = 64'(means_total) / k;
        if (avg > SAMPLE_LIMIT) begin
            avg = SAMPLE_LIMIT;
        end
        err = '0;
        if (k > 64'd1) begin
            msq = squares_total / k;
            var_q = (msq > avg * avg) ? msq - avg * avg : 64'd0;
            var_q = var_q / (k - 64'd1);
            err = 64'(floor_root(var_q));
            if (err > SAMPLE_LIMIT) begin
                err = SAMPLE_LIMIT;
            end
        end
        r.block_index = blocks_done;
        r.running_mean = avg[bae_pkg::SAMPLE_W-1:0];
        r.std_error = err[bae_pkg::SAMPLE_W-1:0];
        r.saturated = (k >= BLOCK_LIMIT);
        stats_due.push_back(r);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task automatic queue_sample(input logic [bae_pkg::SAMPLE_W-1:0] value, input logic restart);
        bae_pkg::in_word_t w;
        w.sample = value;
        w.restart = restart;
        sample_queue.push_back(w);
        n_queued++;
    endtask

    function automatic logic [bae_pkg::SAMPLE_W-1:0] pick_sample(
        input mix_t mix, input logic [bae_pkg::SAMPLE_W-1:0] base);
        logic [bae_pkg::SAMPLE_W-1:0] v;
        case (mix)
            MIX_WIDE: begin
                v = bae_pkg::SAMPLE_W'($urandom);
            end
            MIX_NARROW: begin
                v = base + bae_pkg::SAMPLE_W'($urandom_range(0, 255));
            end
            MIX_EDGES: begin
                case ($urandom_range(0, 2))
                    0: v = '0;
                    1: v = '1;
                    default: v = bae_pkg::SAMPLE_W'(1) <<
                                 $urandom_range(0, bae_pkg::SAMPLE_W - 1);
                endcase
            end
            default: begin
                v = bae_pkg::SAMPLE_W'($urandom_range(0, 1000));
            end
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (words_taken != n_queued || stats_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Length is only written with the block idle
    task automatic set_block_length(input logic [bae_pkg::LEN_W-1:0] len);
        wait_drained();
        repeat (BUSY_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        block_len = len;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Sender: predict on acceptance, then offer the next word or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_block_stats(s_data);
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (sample_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 8)) begin
                    s_valid <= 1'b1;
                    s_data <= sample_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result word, then choose ready for the next cycle
    always @(posedge aclk) begin
        bae_pkg::out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (stats_due.size() == 0) begin
                    flag_mismatch("unexpected word, block_index", 32'(m_data.block_index), 32'd0);
                end else begin
                    want = stats_due.pop_front();
                    if (m_data.block_index !== want.block_index)
                        flag_mismatch("block_index", 32'(m_data.block_index),
                                      32'(want.block_index));
                    if (m_data.running_mean !== want.running_mean)
                        flag_mismatch("running_mean", 32'(m_data.running_mean),
                                      32'(want.running_mean));
                    if (m_data.std_error !== want.std_error)
                        flag_mismatch("std_error", 32'(m_data.std_error), 32'(want.std_error));
                    if (m_data.saturated !== want.saturated)
                        flag_mismatch("saturated", 32'(m_data.saturated), 32'(want.saturated));
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (pressure && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || $urandom_range(0, 99) >= 8;
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int j;
        int n;
        int roll;
        int len_pick;
        int eff;
        int nblocks;
        int phase;
        int rand_items;
        mix_t mix;
        logic [bae_pkg::SAMPLE_W-1:0] base;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset length 1000: two samples leave the block open
        queue_sample('1, 1'b1);
        queue_sample('1, 1'b0);
        // Length lowered mid-block: next sample closes it, mean saturates
        set_block_length(16'd1);
        queue_sample('1, 1'b0);
        set_block_length(16'hFFFF);
        queue_sample('0, 1'b0);
        queue_sample('1, 1'b0);
        // Length zero acts as one
        set_block_length(16'd0);
        queue_sample(24'h123456, 1'b0);
        queue_sample('0, 1'b0);
        queue_sample(24'hAAAAAA, 1'b0);
        queue_sample(24'h555555, 1'b0);
        queue_sample(24'h000001, 1'b0);
        // Equal block means: zero variance
        set_block_length(16'd2);
        queue_sample(24'd7, 1'b1);
        queue_sample(24'd7, 1'b0);
        queue_sample(24'd7, 1'b0);
        queue_sample(24'd7, 1'b0);
        // Restart mid-block drops the partial sum
        set_block_length(16'd3);
        queue_sample(24'd100, 1'b0);
        queue_sample(24'd200, 1'b0);
        queue_sample(24'd300, 1'b1);
        queue_sample(24'd400, 1'b0);
        queue_sample(24'd500, 1'b0);

        // Random phases, each a new length and a few blocks of samples
        rand_items = 0;
        phase = 0;
        wait_drained();
        while (rand_items < 650) begin
            if (phase == 1) begin
                // one word per block under a long receiver hold-off
                set_block_length(16'd0);
                steady <= 1'b0;
                pressure <= 1'b1;
                for (j = 0; j < 30; j++) begin
                    queue_sample(pick_sample(MIX_WIDE, '0), j == 0);
                end
                rand_items += 30;
            end else begin
                roll = $urandom_range(0, 99);
                nblocks = $urandom_range(1, 2);
                if (phase == 2) begin
                    len_pick = 100;
                    nblocks = 2;
                end else if (roll < 35) begin
                    len_pick = $urandom_range(0, 4);
                    nblocks = $urandom_range(1, 6);
                end else if (roll < 45) begin
                    len_pick = $urandom_range(5, 63);
                end else if (roll < 95) begin
                    len_pick = $urandom_range(64, 80);
                end else begin
                    len_pick = $urandom_range(81, 300);
                    nblocks = 1;
                end
                set_block_length(bae_pkg::LEN_W'(len_pick));
                steady <= (phase == 2) || ($urandom_range(0, 9) == 0);
                eff = (len_pick == 0) ? 1 : len_pick;
                n = eff * nblocks + $urandom_range(0, eff / 4);
                mix = mix_t'($urandom_range(0, 3));
                base = bae_pkg::SAMPLE_W'($urandom_range(0, 24'hFFFE00));
                for (j = 0; j < n; j++) begin
                    queue_sample(pick_sample(mix, base),
                                 (j == 0 && $urandom_range(0, 3) == 0) ||
                                 $urandom_range(0, 399) == 0);
                end
                rand_items += n;
            end
            phase++;
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
